// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the frontier edge detector
// Clocked property checks with asynchronous reset masking.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked check, masked while reset is asserted.
`define FED_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("frontier edge detect: check failed");

// Same-cycle implication.
`define FED_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	`FED_ASSERT(label, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication.
`define FED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	`FED_ASSERT(label, clk, rst_n, (ante) |=> (cons))

`endif

// ----- rtl/core/fed_pkg.sv -----
// ---------------------------------------------------------------------------
// fed_pkg
// Types, constants and helpers of the frontier edge detector.
// ---------------------------------------------------------------------------
package fed_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// field widths
	localparam int CFG_W   = 11;
	localparam int VAL_W   = 8;
	localparam int IDX_W   = 20;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 3;
	localparam int REG_SEL_BIT = 2;

	// counter widths
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int PAD_W = $clog2(MAX_WIDTH + 2);
	localparam int CW_MAX = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int CMP_W = ((CW_MAX > CFG_W) ? CW_MAX : CFG_W) + 2;

	localparam int CFG_MIN = 3;
	localparam int WIDTH_RST  = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
	localparam int HEIGHT_RST = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

	// input actions
	localparam logic ACT_CELL = 1'b0;
	localparam logic ACT_PAD  = 1'b1;

	// register indexes (address bit REG_SEL_BIT)
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		CLS_FREE     = 2'd0,
		CLS_UNKNOWN  = 2'd1,
		CLS_OCCUPIED = 2'd2
	} cls_t;

	// one line store entry: older row, newer row
	typedef struct packed {
		cls_t top;
		cls_t mid;
	} line_t;

	localparam int LINE_W = $bits(line_t);

	// one window column
	typedef struct packed {
		cls_t top;
		cls_t mid;
		cls_t bot;
	} wcol_t;

	// neighbour validity of the window centre
	typedef struct packed {
		logic top;
		logic mid;
		logic bot;
		logic left;
		logic right;
	} mask_t;

	// request payload held in stage 1
	typedef struct packed {
		cls_t             cls;
		logic [COL_W-1:0] addr;
		logic             emit;
		logic             last;
		logic [IDX_W-1:0] idx;
		mask_t            mask;
		logic             fwd;
		line_t            fwd_data;
	} item_t;

	// line store write-back
	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
		line_t            data;
	} wr_t;

	function automatic cls_t classify(input logic signed [VAL_W-1:0] v);
		cls_t c;
		if (v == '0)
			c = CLS_FREE;
		else if (v == -'sd1)
			c = CLS_UNKNOWN;
		else
			c = CLS_OCCUPIED;
		return c;
	endfunction

	function automatic logic [CFG_W-1:0] sat_cfg(input logic [CFG_W-1:0] v,
			input int unsigned lim);
		int unsigned vi;
		logic [CFG_W-1:0] r;
		vi = int'(v);
		if (vi < CFG_MIN)
			r = CFG_W'(CFG_MIN);
		else if (vi > lim)
			r = CFG_W'(lim);
		else
			r = v;
		return r;
	endfunction

endpackage

// ----- rtl/core/fed_ram.sv -----
// ---------------------------------------------------------------------------
// fed_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module fed_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/fed_ctrl.sv -----
// ---------------------------------------------------------------------------
// fed_ctrl
// Raster sequencer: positions, flush count, store reads, stage 1 register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fed_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic signed [fed_pkg::VAL_W-1:0] cell_value,
	input  logic [fed_pkg::CFG_W-1:0]        grid_w,
	input  logic [fed_pkg::CFG_W-1:0]        grid_h,
	input  logic                             restart,
	input  logic                             s1_move,
	input  fed_pkg::wr_t                     wr,
	output logic                             rd_en,
	output logic [fed_pkg::COL_W-1:0]        rd_addr,
	output logic                             valid_s1,
	output fed_pkg::item_t                   item_s1
);

	localparam int COL_W = fed_pkg::COL_W;
	localparam int ROW_W = fed_pkg::ROW_W;
	localparam int PAD_W = fed_pkg::PAD_W;
	localparam int CMP_W = fed_pkg::CMP_W;
	localparam int IDX_W = fed_pkg::IDX_W;

	// input position, flush count
	logic [COL_W-1:0] col_q, col_n;
	logic [ROW_W-1:0] row_q, row_n;
	logic [PAD_W-1:0] pad_q, pad_n;
	// position of the next result
	logic [COL_W-1:0] ec_q, ec_n;
	logic [ROW_W-1:0] er_q, er_n;
	logic [IDX_W-1:0] idx_q, idx_n;

	logic             accept, is_cell, pend, act, restart_c, last_p;
	logic             wrap, frame_end, emit;
	logic [COL_W-1:0] c_base, ec_b, addr;
	logic [ROW_W-1:0] r_base, er_b;
	logic [IDX_W-1:0] idx_b;
	logic [CMP_W-1:0] e_x, w_x, h_x;
	fed_pkg::mask_t   mask;

	assign in_ready  = !valid_s1 || s1_move;
	assign accept    = in_valid && in_ready;
	assign is_cell   = (action == fed_pkg::ACT_CELL);
	assign pend      = (pad_q != '0);
	assign act       = is_cell || pend;
	assign restart_c = is_cell && pend;
	assign last_p    = (pad_q == PAD_W'(1));

	assign c_base = restart_c ? '0 : col_q;
	assign r_base = restart_c ? '0 : row_q;
	assign ec_b   = restart_c ? '0 : ec_q;
	assign er_b   = restart_c ? '0 : er_q;
	assign idx_b  = restart_c ? '0 : idx_q;

	assign w_x = CMP_W'(grid_w);
	assign h_x = CMP_W'(grid_h);
	assign e_x = CMP_W'(er_b);

	assign wrap      = (CMP_W'(c_base) + CMP_W'(1)) >= w_x;
	assign frame_end = wrap && ((CMP_W'(r_base) + CMP_W'(1)) >= h_x);

	always_comb begin
		if (is_cell) begin
			addr = c_base;
			emit = (r_base >= ROW_W'(2)) || ((r_base == ROW_W'(1)) && (c_base != '0));
		end else begin
			addr = last_p ? '0 : col_q;
			emit = 1'b1;
		end
	end

	// interior rows 1..H-2 and in-grid columns around the centre
	always_comb begin
		mask.top   = (e_x >= CMP_W'(2)) && ((e_x + CMP_W'(1)) <= h_x);
		mask.mid   = (e_x >= CMP_W'(1)) && ((e_x + CMP_W'(2)) <= h_x);
		mask.bot   = (e_x + CMP_W'(3)) <= h_x;
		mask.left  = (ec_b != '0);
		mask.right = (CMP_W'(ec_b) + CMP_W'(2)) <= w_x;
	end

	always_comb begin
		col_n = col_q;
		row_n = row_q;
		pad_n = pad_q;
		ec_n  = ec_q;
		er_n  = er_q;
		idx_n = idx_q;
		if (accept && act) begin
			if (is_cell) begin
				pad_n = '0;
				if (wrap) begin
					col_n = '0;
					if (frame_end) begin
						row_n = '0;
						pad_n = PAD_W'(grid_w) + PAD_W'(1);
					end else begin
						row_n = r_base + ROW_W'(1);
					end
				end else begin
					col_n = c_base + COL_W'(1);
					row_n = r_base;
				end
			end else begin
				pad_n = pad_q - PAD_W'(1);
				col_n = last_p ? '0 : col_q + COL_W'(1);
			end

			if (!is_cell && last_p) begin
				ec_n  = '0;
				er_n  = '0;
				idx_n = '0;
			end else if (emit) begin
				idx_n = idx_b + IDX_W'(1);
				if ((CMP_W'(ec_b) + CMP_W'(1)) >= w_x) begin
					ec_n = '0;
					er_n = er_b + ROW_W'(1);
				end else begin
					ec_n = ec_b + COL_W'(1);
					er_n = er_b;
				end
			end else begin
				ec_n  = ec_b;
				er_n  = er_b;
				idx_n = idx_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pad_q <= '0;
			ec_q  <= '0;
			er_q  <= '0;
			idx_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
			pad_q <= '0;
			ec_q  <= '0;
			er_q  <= '0;
			idx_q <= '0;
		end else begin
			col_q <= col_n;
			row_q <= row_n;
			pad_q <= pad_n;
			ec_q  <= ec_n;
			er_q  <= er_n;
			idx_q <= idx_n;
		end
	end

	assign rd_en   = accept && act;
	assign rd_addr = addr;

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept && act)
			valid_s1 <= 1'b1;
		else if (s1_move)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept && act) begin
			item_s1.cls      <= is_cell ? fed_pkg::classify(cell_value) : fed_pkg::CLS_OCCUPIED;
			item_s1.addr     <= addr;
			item_s1.emit     <= emit;
			item_s1.last     <= !is_cell && last_p;
			item_s1.idx      <= idx_b;
			item_s1.mask     <= mask;
			// entry written back this cycle is not yet in the store's read data
			item_s1.fwd      <= wr.en && (wr.addr == addr);
			item_s1.fwd_data <= wr.data;
		end
	end

	// during a flush the pad column runs one past the row end
	`FED_ASSERT_IMPL(a_pad_row_zero, clk, arst_n, pad_q != '0, row_q == '0)
	`FED_ASSERT_IMPL(a_col_in_row, clk, arst_n, pad_q == '0, CMP_W'(col_q) < w_x)
	`FED_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !s1_move, $stable(item_s1.idx))

endmodule

// ----- rtl/core/fed_window.sv -----
// ---------------------------------------------------------------------------
// fed_window
// 3x3 window, store write-back, frontier test and output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fed_window (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s1,
	input  fed_pkg::item_t            item_s1,
	input  fed_pkg::line_t            rdata,
	output logic                      s1_move,
	output fed_pkg::wr_t              wr,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [fed_pkg::IDX_W-1:0] cell_index,
	output logic                      is_frontier,
	output logic                      last_cell
);

	localparam fed_pkg::wcol_t WCOL_RST = '{
		top: fed_pkg::CLS_OCCUPIED,
		mid: fed_pkg::CLS_OCCUPIED,
		bot: fed_pkg::CLS_OCCUPIED
	};

	fed_pkg::wcol_t col_a_q, col_b_q, col_new;
	fed_pkg::line_t line;
	fed_pkg::mask_t m;
	logic           out_free, load, hit, hit_l, hit_c, hit_r;

	assign line = item_s1.fwd ? item_s1.fwd_data : rdata;
	assign m    = item_s1.mask;

	assign col_new.top = line.top;
	assign col_new.mid = line.mid;
	assign col_new.bot = item_s1.cls;

	assign out_free = !out_valid || out_ready;
	assign s1_move  = valid_s1 && (!item_s1.emit || out_free);
	assign load     = s1_move && item_s1.emit;

	// rows shift up one in the store
	assign wr.en       = s1_move;
	assign wr.addr     = item_s1.addr;
	assign wr.data.top = line.mid;
	assign wr.data.mid = item_s1.cls;

	// centre is col_b_q.mid once the new column is shifted in
	always_comb begin
		hit_l = m.left && ((m.top && col_a_q.top == fed_pkg::CLS_UNKNOWN) ||
			(m.mid && col_a_q.mid == fed_pkg::CLS_UNKNOWN) ||
			(m.bot && col_a_q.bot == fed_pkg::CLS_UNKNOWN));
		hit_c = (m.top && col_b_q.top == fed_pkg::CLS_UNKNOWN) ||
			(m.bot && col_b_q.bot == fed_pkg::CLS_UNKNOWN);
		hit_r = m.right && ((m.top && col_new.top == fed_pkg::CLS_UNKNOWN) ||
			(m.mid && col_new.mid == fed_pkg::CLS_UNKNOWN) ||
			(m.bot && col_new.bot == fed_pkg::CLS_UNKNOWN));
		hit   = (col_b_q.mid == fed_pkg::CLS_FREE) && (hit_l || hit_c || hit_r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_a_q <= WCOL_RST;
			col_b_q <= WCOL_RST;
		end else if (s1_move) begin
			col_a_q <= col_b_q;
			col_b_q <= col_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (load)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cell_index  <= item_s1.idx;
			is_frontier <= hit;
			last_cell   <= item_s1.last;
		end
	end

	`FED_ASSERT_IMPL(a_no_overwrite, clk, arst_n, load, !out_valid || out_ready)
	`FED_ASSERT_IMPL(a_wr_valid, clk, arst_n, wr.en, valid_s1)

endmodule

// ----- rtl/core/frontier_edge_detect.sv -----
// ---------------------------------------------------------------------------
// frontier_edge_detect
// Streaming 8-connected frontier edge detector over a raster occupancy grid.
// ---------------------------------------------------------------------------
//
//  channel | handshake                     | payload
//  --------+-------------------------------+----------------------------------
//  input   | in_valid / in_ready           | action, cell_value
//  output  | out_valid / out_ready         | cell_index, is_frontier, last_cell
//  config  | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
//  One request per cycle sustained while the output is not stalled; the line
//  store is read once and written once per cell or flush pad, on separate
//  ports, which sets that rate. A result passes through the stage 1 register
//  and then the output register; the first W+1 cells of a frame give no
//  result, and W+1 flush pads drain the rest.
//  Reset clears positions and the window; the line store gets no clearing pass.
//  Output stalls hold stage 1; a request is still taken while stage 1 is empty.
//
// Line store: MAX_WIDTH entries, each the two previous rows of one column.
// A write-back that collides with the next read is forwarded into stage 1.
// A register write saturates the value to 3..MAX and restarts the frame.
// ---------------------------------------------------------------------------
module frontier_edge_detect (
	input  logic                               clk,
	input  logic                               arst_n,
	// cell requests
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               action,
	input  logic signed [fed_pkg::VAL_W-1:0]   cell_value,
	// results
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [fed_pkg::IDX_W-1:0]          cell_index,
	output logic                               is_frontier,
	output logic                               last_cell,
	// register port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [fed_pkg::PADDR_W-1:0]        paddr,
	input  logic [fed_pkg::DATA_W-1:0]         pwdata,
	output logic [fed_pkg::DATA_W-1:0]         prdata,
	output logic                               pready
);

	localparam int CFG_W = fed_pkg::CFG_W;

	logic [CFG_W-1:0]          grid_w_q, grid_h_q, wval;
	logic                      cfg_we;
	logic                      rd_en, valid_s1, s1_move;
	logic [fed_pkg::COL_W-1:0] rd_addr;
	fed_pkg::item_t            item_s1;
	fed_pkg::wr_t              wr;
	fed_pkg::line_t            rdata;

	// register port: no wait states, index in the address bit above the word offset
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign wval   = pwdata[CFG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= CFG_W'(fed_pkg::WIDTH_RST);
			grid_h_q <= CFG_W'(fed_pkg::HEIGHT_RST);
		end else if (cfg_we) begin
			unique case (paddr[fed_pkg::REG_SEL_BIT])
				fed_pkg::REG_WIDTH:  grid_w_q <= fed_pkg::sat_cfg(wval, fed_pkg::MAX_WIDTH);
				fed_pkg::REG_HEIGHT: grid_h_q <= fed_pkg::sat_cfg(wval, fed_pkg::MAX_HEIGHT);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[fed_pkg::REG_SEL_BIT])
			fed_pkg::REG_WIDTH:  prdata = fed_pkg::DATA_W'(grid_w_q);
			fed_pkg::REG_HEIGHT: prdata = fed_pkg::DATA_W'(grid_h_q);
			default:             prdata = '0;
		endcase
	end

	// sequencer and stage 1 register
	fed_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.cell_value (cell_value),
		.grid_w     (grid_w_q),
		.grid_h     (grid_h_q),
		.restart    (cfg_we),
		.s1_move    (s1_move),
		.wr         (wr),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	// two previous rows, one entry per column
	fed_ram #(
		.WIDTH (fed_pkg::LINE_W),
		.DEPTH (fed_pkg::MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// window, frontier test, result register
	fed_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.rdata       (rdata),
		.s1_move     (s1_move),
		.wr          (wr),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cell_index  (cell_index),
		.is_frontier (is_frontier),
		.last_cell   (last_cell)
	);

endmodule

// ----- test/frontier_edge_detect_tb.sv -----
// ----------------------------------------------------------------------------
// frontier_edge_detect_tb
// Self-checking bench for the frontier edge detector. Map frames of many
// shapes, flush pads, stray pads, abandoned flushes and unflushed frames are
// streamed through the request channel under several idle and stall patterns.
// A cycle-free predictor follows every accepted request and the verdicts it
// produces are compared field by field with the results taken from the block.
// ----------------------------------------------------------------------------
module frontier_edge_detect_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fed_pkg::*;

	// one request as queued for the driver
	typedef struct {
		logic                     act;
		logic signed [VAL_W-1:0]  value;
	} cell_req_t;

	// one expected result
	typedef struct {
		logic [IDX_W-1:0] index;
		logic             frontier;
		logic             last;
	} verdict_t;

	localparam int HOLD_CYCLES = 400;   // length of the long receiver hold-off
	localparam int SETTLE      = 8;     // cycles allowed for work still in flight

	// ------------------------------------------------------------------
	// DUT ports; every input has a known value from time zero
	// ------------------------------------------------------------------
	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	logic                      action      = ACT_CELL;
	logic signed [VAL_W-1:0]   cell_value  = '0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	logic [IDX_W-1:0]          cell_index;
	logic                      is_frontier;
	logic                      last_cell;
	logic                      psel        = 1'b0;
	logic                      penable     = 1'b0;
	logic                      pwrite      = 1'b0;
	logic [PADDR_W-1:0]        paddr       = '0;
	logic [DATA_W-1:0]         pwdata      = '0;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;

	frontier_edge_detect u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.cell_value  (cell_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cell_index  (cell_index),
		.is_frontier (is_frontier),
		.last_cell   (last_cell),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// ------------------------------------------------------------------
	// Bench state
	// ------------------------------------------------------------------
	cell_req_t cell_requests[$];     // requests waiting for the driver
	verdict_t  cell_verdicts[$];     // results owed by the block, oldest first
	int        requests_queued = 0;
	int        requests_taken  = 0;
	int        mismatches      = 0;
	int        send_idle_pct   = 0;  // chance in 100 that the sender rests
	int        recv_stall_pct  = 0;  // chance in 100 that the receiver stalls
	int        holds_asked     = 0;  // long hold-offs asked for by the sequence
	int        holds_served    = 0;
	int        hold_left       = 0;
	cell_req_t drv_req;
	verdict_t  want;
	verdict_t  fresh;

	// ------------------------------------------------------------------
	// Predictor state: geometry, frame position, line stores and window
	// ------------------------------------------------------------------
	int   grid_w;
	int   grid_h;
	int   col_pos;
	int   row_pos;
	int   pads_left;                 // flush pads still owed after a frame
	cls_t row_older [MAX_WIDTH];     // two rows up
	cls_t row_newer [MAX_WIDTH];     // one row up
	cls_t win [3][3];                // [row][column], newest column at 2

	function automatic void restart_frame();
		col_pos   = 0;
		row_pos   = 0;
		pads_left = 0;
	endfunction

	function automatic void reset_model();
		grid_w = WIDTH_RST;
		grid_h = HEIGHT_RST;
		// store content is unobservable until written; free is as good as any
		foreach (row_older[i]) begin
			row_older[i] = CLS_FREE;
			row_newer[i] = CLS_FREE;
		end
		foreach (win[r, c])
			win[r][c] = CLS_OCCUPIED;
		restart_frame();
	endfunction

	function automatic void apply_reg(logic sel, logic [DATA_W-1:0] data);
		int v;
		int lim;
		v   = int'(data[CFG_W-1:0]);
		lim = (sel == REG_WIDTH) ? MAX_WIDTH : MAX_HEIGHT;
		if (v < CFG_MIN)
			v = CFG_MIN;
		if (v > lim)
			v = lim;
		if (sel == REG_WIDTH)
			grid_w = v;
		else
			grid_h = v;
		restart_frame();
	endfunction

	function automatic cls_t cell_class(logic signed [VAL_W-1:0] value);
		case (value)
			'0:      return CLS_FREE;
			'1:      return CLS_UNKNOWN;
			default: return CLS_OCCUPIED;
		endcase
	endfunction

	// push one column into the window and rotate the line stores behind it
	function automatic void shift_column(int col, cls_t newest);
		cls_t older;
		cls_t newer;
		older = row_older[col];
		newer = row_newer[col];
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = older;
		win[1][2] = newer;
		win[2][2] = newest;
		row_older[col] = newer;
		row_newer[col] = newest;
	endfunction

	// verdict for the window centre, which sits at (r, c)
	function automatic verdict_t judge_centre(int r, int c, logic last);
		verdict_t v;
		logic     hit;
		int       nr;
		int       nc;
		hit = 1'b0;
		if (win[1][1] == CLS_FREE) begin
			for (int dr = -1; dr <= 1; dr++) begin
				nr = r + dr;
				// only unknown cells in interior rows count
				if (nr >= 1 && nr <= grid_h - 2) begin
					for (int dc = -1; dc <= 1; dc++) begin
						nc = c + dc;
						if ((dr != 0 || dc != 0) && nc >= 0 && nc < grid_w &&
								win[dr + 1][dc + 1] == CLS_UNKNOWN)
							hit = 1'b1;
					end
				end
			end
		end
		v.index    = IDX_W'(r * grid_w + c);
		v.frontier = hit;
		v.last     = last;
		return v;
	endfunction

	// advance the predictor by one accepted request; 1 when a result is owed
	function automatic bit frontier_step(logic act, logic signed [VAL_W-1:0] value,
			output verdict_t v);
		int r;
		int c;
		int p;
		bit produced;
		produced = 1'b0;
		if (act == ACT_CELL) begin
			// a cell during a flush drops the rest of it and opens a new frame
			if (pads_left != 0)
				restart_frame();
			r = row_pos;
			c = col_pos;
			shift_column(c, cell_class(value));
			if (r >= 2 || (r == 1 && c >= 1)) begin
				if (c >= 1)
					v = judge_centre(r - 1, c - 1, 1'b0);
				else
					v = judge_centre(r - 2, grid_w - 1, 1'b0);
				produced = 1'b1;
			end
			c++;
			if (c >= grid_w) begin
				c = 0;
				r++;
				if (r >= grid_h) begin
					r = 0;
					pads_left = grid_w + 1;
				end
			end
			col_pos = c;
			row_pos = r;
		end else if (pads_left != 0) begin
			p = grid_w + 1 - pads_left;
			shift_column((p < grid_w) ? p : 0, CLS_OCCUPIED);
			if (p >= 1)
				v = judge_centre(grid_h - 1, p - 1, p == grid_w);
			else
				v = judge_centre(grid_h - 2, grid_w - 1, 1'b0);
			pads_left--;
			produced = 1'b1;
		end
		// a pad with no flush owed changes nothing
		return produced;
	endfunction

	// ------------------------------------------------------------------
	// Mismatch reporting: one line each, all counted
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		mismatches++;
		$display("%0t ns: mismatch on %s: got %0d, expected %0d",
			$time, what, got, exp_val);
	endtask

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Request driver: valid is held with its payload until taken; after a
	// take it either offers the next request or rests, at random
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!in_valid || in_ready) begin
			if (arst_n && cell_requests.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				drv_req = cell_requests.pop_front();
				in_valid   <= 1'b1;
				action     <= drv_req.act;
				cell_value <= drv_req.value;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: random stalls, plus a long hold-off on request from
	// the sequence, counted here so the block backs up into its input
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (holds_served != holds_asked) begin
			holds_served = holds_asked;
			hold_left    = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check the result taken at this edge against the oldest
	// verdict, then feed the request taken at this edge to the predictor.
	// Results trail requests via stage 1 and the output register; order is safe.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (cell_verdicts.size() == 0) begin
					report_mismatch("result with nothing owed, cell_index",
						32'(cell_index), '1);
				end else begin
					want = cell_verdicts.pop_front();
					if (cell_index !== want.index)
						report_mismatch("cell_index", 32'(cell_index), 32'(want.index));
					if (is_frontier !== want.frontier)
						report_mismatch($sformatf("is_frontier of cell %0d", want.index),
							32'(is_frontier), 32'(want.frontier));
					if (last_cell !== want.last)
						report_mismatch($sformatf("last_cell of cell %0d", want.index),
							32'(last_cell), 32'(want.last));
				end
			end
			if (in_valid && in_ready) begin
				if (frontier_step(action, cell_value, fresh))
					cell_verdicts.insert(cell_verdicts.size(), fresh);
				requests_taken++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence helpers
	// ------------------------------------------------------------------
	function automatic void queue_cell(logic signed [VAL_W-1:0] value);
		cell_req_t q;
		q.act   = ACT_CELL;
		q.value = value;
		cell_requests.insert(cell_requests.size(), q);
		requests_queued++;
	endfunction

	function automatic void queue_pad();
		cell_req_t q;
		q.act   = ACT_PAD;
		q.value = VAL_W'($urandom);   // payload is a don't-care for pads
		cell_requests.insert(cell_requests.size(), q);
		requests_queued++;
	endfunction

	// unknown_pct sets how patchy the map is
	function automatic logic signed [VAL_W-1:0] draw_value(int unknown_pct);
		int roll;
		roll = $urandom_range(99);
		if (roll < unknown_pct)
			return '1;
		if (roll < unknown_pct + (100 - unknown_pct) / 2)
			return '0;
		if ($urandom_range(1))
			return VAL_W'($urandom_range(1, 100));
		return VAL_W'($urandom_range(255));
	endfunction

	function automatic int queue_frame(int cells, int pads, int unknown_pct);
		for (int i = 0; i < cells; i++)
			queue_cell(draw_value(unknown_pct));
		for (int i = 0; i < pads; i++)
			queue_pad();
		return cells + pads;
	endfunction

	// mostly whole frames with full flushes; the rest is noise
	function automatic void queue_random(int budget, int w, int h);
		int done;
		int roll;
		int pads;
		done = 0;
		while (done < budget) begin
			roll = $urandom_range(99);
			if (roll < 8) begin
				queue_pad();                                    // stray pad
			end else if (roll < 16) begin
				done += queue_frame($urandom_range(1, w * h - 1), 0,
					$urandom_range(10, 60));                    // broken frame
			end else begin
				pads = ($urandom_range(9) == 0) ? $urandom_range(0, w) : w + 1;
				done += queue_frame(w * h, pads, $urandom_range(10, 60));
			end
		end
	endfunction

	function automatic void set_idling(int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
			default: begin send_idle_pct = 6; recv_stall_pct = 6; end
		endcase
	endfunction

	// APB write: setup, then access until pready; predictor follows at once
	task automatic write_reg(logic sel, logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(sel) << REG_SEL_BIT;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		apply_reg(sel, data);
		@(posedge clk);
	endtask

	// everything queued taken, every result in, and a margin for requests
	// that owed no result but may still sit in the pipeline
	task automatic wait_drained();
		while (requests_taken != requests_queued || cell_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int w;
		int h;
		logic [DATA_W-1:0] raw;
		reset_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on a 3x3 map. Both writes lie below range and
		// saturate up to the minimum.
		set_idling(0);
		write_reg(REG_WIDTH, 32'd0);
		write_reg(REG_HEIGHT, 32'd2);
		queue_pad();                          // no flush owed: ignored
		queue_cell(0);    queue_cell(0);    queue_cell(-1);
		queue_cell(-1);   queue_cell(0);    queue_cell(100);
		queue_cell(0);    queue_cell(-128); queue_cell(127);
		repeat (4) queue_pad();               // full flush, last cell flagged
		queue_pad();                          // flush done: ignored again
		// a frame left unflushed, then a flush cut short by a new cell
		queue_cell(0);    queue_cell(-1);   queue_cell(0);
		queue_cell(0);    queue_cell(1);    queue_cell(-1);
		queue_cell(0);    queue_cell(0);    queue_cell(0);
		queue_pad();      queue_pad();
		queue_cell(0);
		wait_drained();

		// Random part: small maps mostly, every idle pattern in turn
		for (int ph = 0; ph < 12; ph++) begin
			set_idling(ph % 4);
			w = ($urandom_range(4) == 0) ? $urandom_range(9, 40) : $urandom_range(3, 8);
			h = $urandom_range(3, 8);
			case ($urandom_range(3))
				0: raw = ($urandom & ~32'h7FF) | DATA_W'(w);   // junk in upper bits
				1: raw = DATA_W'($urandom_range(0, 2));         // below range
				default: raw = DATA_W'(w);
			endcase
			write_reg(REG_WIDTH, raw);
			write_reg(REG_HEIGHT, DATA_W'(h));
			// long hold-off while the sender keeps offering: block backs up
			if (ph == 2)
				holds_asked++;
			queue_random(30, grid_w, grid_h);
			wait_drained();
		end

		// Extremes, both reached by saturation. Widest map: a row and a few
		// cells, enough for results that show the row length.
		set_idling(0);
		write_reg(REG_WIDTH, 32'd2047);
		write_reg(REG_HEIGHT, 32'd3);
		void'(queue_frame(grid_w + 16, 0, 30));
		wait_drained();
		// tallest map: the opening rows of a frame
		write_reg(REG_HEIGHT, 32'd1025);
		write_reg(REG_WIDTH, 32'hFFFF_F800);    // low bits zero: minimum width
		void'(queue_frame(20 * grid_w, 0, 30));
		wait_drained();

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
